// ===== sv/lesf_pkg.sv =====
`default_nettype none

package lesf_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int CHAR_W      = 8;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;
	localparam int X_W         = 10;
	localparam int Y_W         = 10;
	localparam int SIZE_W      = 11;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_WIDTH    = 2'd0,
		REG_GRID_HEIGHT   = 2'd1,
		REG_OBSTACLE_CHAR = 2'd2
	} cfg_reg_t;

	localparam int                GRID_RESET     = 1024;
	localparam logic [CHAR_W-1:0] OBSTACLE_RESET = 8'd111;

	// where a cell sits in the frame
	typedef struct packed {
		logic row0;
		logic col0;
		logic frame_end;
	} cell_pos_t;

endpackage

`default_nettype wire

// ===== sv/lesf_row_mem.sv =====
`default_nettype none

module lesf_row_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/lesf_best.sv =====
`default_nettype none

module lesf_best #(
	parameter int CW = 10,
	parameter int HW = 10,
	parameter int RW = 11
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        clear,
	input  wire logic                        vld_s1,
	input  wire logic [RW-1:0]               run_s1,
	input  wire logic [CW-1:0]               col_s1,
	input  wire logic [HW-1:0]               row_s1,
	input  wire lesf_pkg::cell_pos_t         pos_s1,
	output logic                             hold,
	output logic                             found_valid,
	input  wire logic                        found_ready,
	output logic [lesf_pkg::X_W-1:0]         found_x,
	output logic [lesf_pkg::Y_W-1:0]         found_y,
	output logic [lesf_pkg::SIZE_W-1:0]      found_size
);

	import lesf_pkg::*;

	logic            vld_s2;
	logic [RW-1:0]   run_s2;
	logic [CW-1:0]   col_s2;
	logic [HW-1:0]   row_s2;
	cell_pos_t       pos_s2;

	logic [RW-1:0]   best_size_q;
	logic [CW-1:0]   best_x_q;
	logic [HW-1:0]   best_y_q;

	logic            take;
	logic [CW:0]     cand_x;
	logic [HW:0]     cand_y;
	logic [RW-1:0]   nxt_size;
	logic [CW-1:0]   nxt_x;
	logic [HW-1:0]   nxt_y;

	// stall only when a frame result meets a full output register
	assign hold = vld_s2 && pos_s2.frame_end && found_valid && !found_ready;

	assign take   = run_s2 > best_size_q;
	assign cand_x = {1'b0, col_s2} + (CW+1)'(1) - (CW+1)'(run_s2);
	assign cand_y = {1'b0, row_s2} + (HW+1)'(1) - (HW+1)'(run_s2);

	always_comb begin
		nxt_size = best_size_q;
		nxt_x    = best_x_q;
		nxt_y    = best_y_q;
		if (take) begin
			nxt_size = run_s2;
			nxt_x    = cand_x[CW-1:0];
			nxt_y    = cand_y[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!hold) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			run_s2 <= run_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			pos_s2 <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_size_q <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
		end else if (clear) begin
			best_size_q <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
		end else if (vld_s2 && !hold) begin
			if (pos_s2.frame_end) begin
				best_size_q <= '0;
				best_x_q    <= '0;
				best_y_q    <= '0;
			end else begin
				best_size_q <= nxt_size;
				best_x_q    <= nxt_x;
				best_y_q    <= nxt_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_valid <= 1'b0;
		end else if (vld_s2 && pos_s2.frame_end && !hold) begin
			found_valid <= 1'b1;
		end else if (found_ready) begin
			found_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && pos_s2.frame_end && !hold) begin
			found_x    <= X_W'(nxt_x);
			found_y    <= Y_W'(nxt_y);
			found_size <= SIZE_W'(nxt_size);
		end
	end

endmodule

`default_nettype wire

// ===== sv/largest_empty_square_finder.sv =====
`default_nettype none

// channel    dir  handshake                 payload
// cell       in   cell_valid / cell_ready   cell_char
// found      out  found_valid / found_ready found_x, found_y, found_size
// cfg        in   cfg_we (no wait)          cfg_index, cfg_wdata
//
// One cell per cycle while cell_ready is high. A cell reads the row buffer in the
// cycle it is taken, combines the read data with its left and upper-left neighbors
// in the next cycle and writes back, and then updates the best square in the stage
// after that; the result is registered when the last cell of a frame reaches that
// stage. Reset clears position, best square and handshakes; the row buffer needs no
// clearing. Input stalls only while a finished result waits in the output register
// and the next frame's last cell arrives at the best-square stage.
module largest_empty_square_finder #(
	parameter int MAX_WIDTH  = lesf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lesf_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cell_valid,
	output logic                                 cell_ready,
	input  wire logic [lesf_pkg::CHAR_W-1:0]     cell_char,
	output logic                                 found_valid,
	input  wire logic                            found_ready,
	output logic [lesf_pkg::X_W-1:0]             found_x,
	output logic [lesf_pkg::Y_W-1:0]             found_y,
	output logic [lesf_pkg::SIZE_W-1:0]          found_size,
	input  wire logic                            cfg_we,
	input  wire logic [lesf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import lesf_pkg::*;

	localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int MIN_DIM = (MAX_WIDTH < MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int RW      = $clog2(MIN_DIM + 1);
	localparam int W_RST   = ((GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET) - 1;
	localparam int H_RST   = ((GRID_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RESET) - 1;

	function automatic int last_index(input logic [CFG_DATA_W-1:0] v, input int maxv);
		int t;
		if (v == '0) begin
			t = 0;
		end else if (int'(v) > maxv) begin
			t = maxv - 1;
		end else begin
			t = int'(v) - 1;
		end
		return t;
	endfunction

	logic              hold;
	logic              adv;
	logic              acc;
	logic              restart;

	logic [CW-1:0]     width_last_q;
	logic [HW-1:0]     height_last_q;
	logic [CHAR_W-1:0] obst_q;
	logic [CW-1:0]     col_q;
	logic [HW-1:0]     row_q;
	logic              col_end;
	logic              row_end;
	cell_pos_t         pos;

	logic              vld_s1;
	logic [CW-1:0]     col_s1;
	logic [HW-1:0]     row_s1;
	cell_pos_t         pos_s1;
	logic              obst_s1;
	logic              fwd_s1;
	logic [RW-1:0]     fwd_run_s1;

	logic [RW-1:0]     left_q;
	logic [RW-1:0]     upleft_q;
	logic [RW-1:0]     rd_data;
	logic [RW-1:0]     up;
	logic [RW-1:0]     left;
	logic [RW-1:0]     diag;
	logic [RW-1:0]     min_ul;
	logic [RW-1:0]     min3;
	logic [RW-1:0]     run;

	assign adv        = !hold;
	assign cell_ready = adv;
	assign acc        = cell_valid && adv;
	assign restart    = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

	assign col_end       = col_q == width_last_q;
	assign row_end       = row_q == height_last_q;
	assign pos.row0      = row_q == '0;
	assign pos.col0      = col_q == '0;
	assign pos.frame_end = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= CW'(W_RST);
			height_last_q <= HW'(H_RST);
			obst_q        <= OBSTACLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:    width_last_q  <= CW'(last_index(cfg_wdata, MAX_WIDTH));
				REG_GRID_HEIGHT:   height_last_q <= HW'(last_index(cfg_wdata, MAX_HEIGHT));
				REG_OBSTACLE_CHAR: obst_q        <= cfg_wdata[CHAR_W-1:0];
				default:           ;
			endcase
		end
	end

	// raster position of the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1     <= col_q;
			row_s1     <= row_q;
			pos_s1     <= pos;
			obst_s1    <= cell_char == obst_q;
			// the read misses a write landing on the same column this cycle
			fwd_s1     <= vld_s1 && (col_s1 == col_q);
			fwd_run_s1 <= run;
		end
	end

	lesf_row_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (RW)
	) u_row_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (vld_s1 && adv),
		.wr_addr (col_s1),
		.wr_data (run)
	);

	always_comb begin
		up     = pos_s1.row0 ? '0 : (fwd_s1 ? fwd_run_s1 : rd_data);
		left   = pos_s1.col0 ? '0 : left_q;
		diag   = (pos_s1.row0 || pos_s1.col0) ? '0 : upleft_q;
		min_ul = (up < left) ? up : left;
		min3   = (min_ul < diag) ? min_ul : diag;
		run    = obst_s1 ? '0 : min3 + RW'(1);
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && adv) begin
			left_q   <= run;
			upleft_q <= up;
		end
	end

	lesf_best #(
		.CW (CW),
		.HW (HW),
		.RW (RW)
	) u_best (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (restart),
		.vld_s1      (vld_s1),
		.run_s1      (run),
		.col_s1      (col_s1),
		.row_s1      (row_s1),
		.pos_s1      (pos_s1),
		.hold        (hold),
		.found_valid (found_valid),
		.found_ready (found_ready),
		.found_x     (found_x),
		.found_y     (found_y),
		.found_size  (found_size)
	);

endmodule

`default_nettype wire

// ===== bench/largest_empty_square_finder_tb.sv =====
`timescale 1ns / 1ps

module largest_empty_square_finder_tb;
	import lesf_pkg::*;

	localparam int MAX_W        = DEF_MAX_WIDTH;
	localparam int MAX_H        = DEF_MAX_HEIGHT;
	localparam int LATENCY      = 6;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_CELLS = 450;
	localparam int REPORT_MAX   = 10;

	// index with no register behind it
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [X_W-1:0]    col;
		logic [Y_W-1:0]    row;
		logic [SIZE_W-1:0] side;
	} square_t;

	typedef enum logic [1:0] {
		FILL_FREE,
		FILL_BLOCKED,
		FILL_MIXED
	} fill_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		logic [CHAR_W-1:0]     obst;
		int                    cells;
		fill_t                 fill;
		logic [CHAR_W-1:0]     free_char;
		logic                  typed;
		square_t               want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 8;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{11'd1, 11'd1, 8'd111, 1, FILL_FREE, 8'd0, 1'b1, '{10'd0, 10'd0, 11'd1}},
		'{11'd1, 11'd1, 8'd111, 1, FILL_BLOCKED, 8'd0, 1'b1, '{10'd0, 10'd0, 11'd0}},
		// zero sizes count as one
		'{11'd0, 11'd0, 8'd255, 1, FILL_FREE, 8'd0, 1'b1, '{10'd0, 10'd0, 11'd1}},
		'{11'd2, 11'd2, 8'd0, 4, FILL_FREE, 8'd255, 1'b1, '{10'd0, 10'd0, 11'd2}},
		'{11'd3, 11'd2, 8'd255, 6, FILL_BLOCKED, 8'd0, 1'b1, '{10'd0, 10'd0, 11'd0}},
		// equal squares: the first one stays
		'{11'd3, 11'd1, 8'd111, 3, FILL_FREE, 8'd110, 1'b1, '{10'd0, 10'd0, 11'd1}},
		// frame cut short, then dropped by the next size write
		'{11'd3, 11'd3, 8'd111, 4, FILL_MIXED, 8'd0, 1'b0, '0},
		'{11'd4, 11'd2, 8'd128, 8, FILL_MIXED, 8'd0, 1'b0, '0}
	};

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cell_valid  = 1'b0;
	logic                   cell_ready;
	logic [CHAR_W-1:0]      cell_char   = '0;
	logic                   found_valid;
	logic                   found_ready = 1'b0;
	logic [X_W-1:0]         found_x;
	logic [Y_W-1:0]         found_y;
	logic [SIZE_W-1:0]      found_size;
	logic                   cfg_we      = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = REG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;

	largest_empty_square_finder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_ready  (cell_ready),
		.cell_char   (cell_char),
		.found_valid (found_valid),
		.found_ready (found_ready),
		.found_x     (found_x),
		.found_y     (found_y),
		.found_size  (found_size),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// shadow of the block's registers and frame state
	logic [CFG_DATA_W-1:0] grid_w_cfg = CFG_DATA_W'(GRID_RESET);
	logic [CFG_DATA_W-1:0] grid_h_cfg = CFG_DATA_W'(GRID_RESET);
	logic [CHAR_W-1:0]     obst_cfg   = OBSTACLE_RESET;
	logic [SIZE_W-1:0]     row_above [MAX_W];
	logic [SIZE_W-1:0]     run_left   = '0;
	logic [SIZE_W-1:0]     run_upleft = '0;
	logic [X_W-1:0]        col_pos    = '0;
	logic [Y_W-1:0]        row_pos    = '0;
	logic [SIZE_W-1:0]     best_side  = '0;
	logic [X_W-1:0]        best_col   = '0;
	logic [Y_W-1:0]        best_row   = '0;

	square_t pending_squares [$];
	int      mismatch_count = 0;
	int      send_idle_pct  = 26;
	int      recv_idle_pct  = 62;
	int      hold_asked     = 0;
	int      hold_taken     = 0;
	int      hold_left      = 0;
	int      quiet_cycles   = 0;

	function automatic void restart_frame();
		run_left   = '0;
		run_upleft = '0;
		col_pos    = '0;
		row_pos    = '0;
		best_side  = '0;
		best_col   = '0;
		best_row   = '0;
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
		input int top);
		if (v == '0)
			return SIZE_W'(1);
		if (int'(v) > top)
			return top[SIZE_W-1:0];
		return v;
	endfunction

	// advance the frame by one cell; returns 1 when the frame closes
	function automatic bit grow_square(input logic [CHAR_W-1:0] ch, output square_t sq);
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [SIZE_W-1:0] c;
		logic [SIZE_W-1:0] r;
		logic [SIZE_W-1:0] up;
		logic [SIZE_W-1:0] diag;
		logic [SIZE_W-1:0] lft;
		logic [SIZE_W-1:0] v;
		w  = clamp_dim(grid_w_cfg, MAX_W);
		h  = clamp_dim(grid_h_cfg, MAX_H);
		sq = '0;
		if (SIZE_W'(col_pos) >= w || SIZE_W'(row_pos) >= h)
			restart_frame();
		c    = SIZE_W'(col_pos);
		r    = SIZE_W'(row_pos);
		up   = (r != '0) ? row_above[col_pos] : '0;
		diag = (r != '0 && c != '0) ? run_upleft : '0;
		lft  = (c != '0) ? run_left : '0;
		if (ch == obst_cfg) begin
			v = '0;
		end else begin
			v = up;
			if (diag < v)
				v = diag;
			if (lft < v)
				v = lft;
			v = v + SIZE_W'(1);
		end
		run_upleft         = up;
		run_left           = v;
		row_above[col_pos] = v;
		if (v > best_side) begin
			best_side = v;
			best_col  = X_W'(c + SIZE_W'(1) - v);
			best_row  = Y_W'(r + SIZE_W'(1) - v);
		end
		if (c + SIZE_W'(1) < w) begin
			col_pos = X_W'(c + SIZE_W'(1));
			return 1'b0;
		end
		col_pos    = '0;
		run_left   = '0;
		run_upleft = '0;
		if (r + SIZE_W'(1) < h) begin
			row_pos = Y_W'(r + SIZE_W'(1));
			return 1'b0;
		end
		sq = '{best_col, best_row, best_side};
		restart_frame();
		return 1'b1;
	endfunction

	function automatic logic [CHAR_W-1:0] mixed_char(input logic [CHAR_W-1:0] obst,
		input int blocked_pct);
		if ($urandom_range(99) < blocked_pct)
			return obst;
		return CHAR_W'($urandom_range(255));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 11'd1;
			2:       return 11'($urandom_range(24, 12));
			default: return 11'($urandom_range(8, 2));
		endcase
	endfunction

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_GRID_WIDTH: begin
				grid_w_cfg = data;
				restart_frame();
			end
			REG_GRID_HEIGHT: begin
				grid_h_cfg = data;
				restart_frame();
			end
			REG_OBSTACLE_CHAR: begin
				obst_cfg = data[CHAR_W-1:0];
			end
			default: ;
		endcase
	endtask

	// wait for every expected square, then let the pipeline empty
	task automatic settle();
		cell_valid <= 1'b0;
		while (pending_squares.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
		input logic [CHAR_W-1:0] obst);
		settle();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(2047)));
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_OBSTACLE_CHAR, {3'($urandom_range(7)), obst});
		cfg_we <= 1'b0;
	endtask

	task automatic offer_cell(input logic [CHAR_W-1:0] ch, input logic typed,
		input square_t want);
		square_t sq;
		cell_valid <= 1'b1;
		cell_char  <= ch;
		@(posedge clk);
		while (!cell_ready)
			@(posedge clk);
		if (grow_square(ch, sq))
			pending_squares.push_back(typed ? want : sq);
		if ($urandom_range(99) < send_idle_pct) begin
			cell_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_frames(input int frames, input int blocked_pct, inout int spent);
		int cells;
		cells = int'(clamp_dim(grid_w_cfg, MAX_W)) * int'(clamp_dim(grid_h_cfg, MAX_H));
		repeat (frames) begin
			repeat (cells)
				offer_cell(mixed_char(obst_cfg, blocked_pct), 1'b0, '0);
			spent += cells;
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			found_ready <= 1'b0;
			hold_left   <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			hold_taken  <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			found_ready <= 1'b0;
		end else begin
			found_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		square_t got;
		square_t want;
		if (arst_n && found_valid && found_ready) begin
			got = '{found_x, found_y, found_size};
			if (pending_squares.size() == 0) begin
				if (mismatch_count < REPORT_MAX)
					$display("unexpected found beat: x=%0d y=%0d size=%0d",
						got.col, got.row, got.side);
				mismatch_count++;
			end else begin
				want = pending_squares.pop_front();
				if (got.col !== want.col || got.row !== want.row || got.side !== want.side) begin
					if (mismatch_count < REPORT_MAX)
						$display("found beat mismatch: want x=%0d y=%0d size=%0d, got x=%0d y=%0d size=%0d",
							want.col, want.row, want.side, got.col, got.row, got.side);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cell_valid && cell_ready) || (found_valid && found_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		directed_row_t     row;
		logic [CHAR_W-1:0] ch;
		int                spent;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			configure(row.width, row.height, row.obst);
			for (int k = 0; k < row.cells; k++) begin
				case (row.fill)
					FILL_FREE:    ch = row.free_char;
					FILL_BLOCKED: ch = row.obst;
					default:      ch = mixed_char(row.obst, 30);
				endcase
				offer_cell(ch, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			settle();
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 26 : 0;
			spent = 0;
			case (phase)
				0: begin
					// widest row: all-ones width clamps to the maximum
					configure(11'h7FF, 11'd1, 8'($urandom_range(255)));
					send_frames(1, 5, spent);
				end
				1: begin
					configure(11'd0, 11'd96, 8'($urandom_range(255)));
					send_frames(1, 20, spent);
				end
				default: begin
					// single-cell frames pile up behind a stalled receiver
					configure(11'd1, 11'd1, 8'($urandom_range(255)));
					hold_asked++;
					send_frames(16, 30, spent);
				end
			endcase
			spent = 0;
			while (spent < RANDOM_CELLS / 3) begin
				case ($urandom_range(3))
					0:       ch = '0;
					1:       ch = 8'hFF;
					default: ch = 8'($urandom_range(255));
				endcase
				configure(pick_dim(), pick_dim(), ch);
				send_frames($urandom_range(3, 1), $urandom_range(45), spent);
			end
		end

		settle();
		if (mismatch_count == 0 && pending_squares.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lesf_pkg.sv
sv/lesf_row_mem.sv
sv/lesf_best.sv
sv/largest_empty_square_finder.sv
bench/largest_empty_square_finder_tb.sv
